@@ src/clr_pkg.sv @@
package clr_pkg;

  localparam int COORD_W = 16;
  localparam int PIX_W = 6;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] MAP_DIM_RESET = 7'd64;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_start;
    logic signed [COORD_W-1:0] y_start;
    logic signed [COORD_W-1:0] x_end;
    logic signed [COORD_W-1:0] y_end;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             last_pixel;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } status_t;

endpackage

@@ src/clr_ctrl.sv @@
module clr_ctrl
  import clr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.out_free && status.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_RUN: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ src/clr_datapath.sv @@
module clr_datapath
  import clr_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  in_item_t               in_data,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data
);

  localparam int CW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int DIMW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] map_width;
  logic [CFG_DATA_W-1:0] map_height;
  logic [CW-1:0] lim_x;
  logic [CW-1:0] lim_y;

  logic [CW-1:0] x1, y1, x2, y2;

  logic [CW-1:0] dx, dy;
  logic          x_major_c;
  logic          swap;
  logic [CW-1:0] sx, sy, ex, ey;

  logic          x_major;
  logic [CW-1:0] maj;
  logic [CW-1:0] minor;
  logic          neg;
  logic [CW-1:0] mag;
  logic [CW-1:0] major;
  logic [CW-1:0] cnt;
  logic [CW:0]   rem;
  logic [CW:0]   rem_sum;
  logic          wrap;
  logic [CW-1:0] px, py;

  function automatic logic [CW-1:0] dim_limit(input logic [CFG_DATA_W-1:0] reg_val);
    logic [DIMW-1:0] d;
    d = DIMW'(reg_val);
    if (d == '0) begin
      d = DIMW'(1);
    end else if (d > DIMW'(MAX_DIM)) begin
      d = DIMW'(MAX_DIM);
    end
    return CW'(d - DIMW'(1));
  endfunction

  function automatic logic [CW-1:0] clamp_coord(input logic [COORD_W-1:0] v,
                                                input logic [CW-1:0] lim);
    logic [CW-1:0] r;
    if (v[COORD_W-1]) begin
      r = '0;
    end else if (v > COORD_W'(lim)) begin
      r = lim;
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= MAP_DIM_RESET;
      map_height <= MAP_DIM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAP_WIDTH: begin
          map_width <= cfg_data;
        end
        REG_MAP_HEIGHT: begin
          map_height <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign lim_x = dim_limit(map_width);
  assign lim_y = dim_limit(map_height);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1 <= clamp_coord(in_data.x_start, lim_x);
      y1 <= clamp_coord(in_data.y_start, lim_y);
      x2 <= clamp_coord(in_data.x_end, lim_x);
      y2 <= clamp_coord(in_data.y_end, lim_y);
    end
  end

  always_comb begin
    dx = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy = (y1 > y2) ? y1 - y2 : y2 - y1;
    x_major_c = dx > dy;
    swap = x_major_c ? (x1 > x2) : (y1 > y2);
    sx = swap ? x2 : x1;
    sy = swap ? y2 : y1;
    ex = swap ? x1 : x2;
    ey = swap ? y1 : y2;
  end

  assign rem_sum = rem + (CW + 1)'(mag);
  assign wrap = rem_sum >= (CW + 1)'(major);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      x_major <= x_major_c;
      rem <= '0;
      if (x_major_c) begin
        maj <= sx;
        minor <= sy;
        neg <= ey < sy;
        mag <= dy;
        major <= dx;
        cnt <= dx;
      end else begin
        maj <= sy;
        minor <= sx;
        neg <= ex < sx;
        mag <= dx;
        major <= dy;
        cnt <= dy;
      end
    end else if (cmd.emit) begin
      maj <= maj + CW'(1);
      cnt <= cnt - CW'(1);
      if (wrap) begin
        rem <= rem_sum - (CW + 1)'(major);
        minor <= neg ? minor - CW'(1) : minor + CW'(1);
      end else begin
        rem <= rem_sum;
      end
    end
  end

  assign px = x_major ? maj : minor;
  assign py = x_major ? minor : maj;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.pixel_x <= PIX_W'(px);
      out_data.pixel_y <= PIX_W'(py);
      out_data.last_pixel <= cnt == '0;
    end
  end

  assign status.out_free = !out_valid || out_ready;
  assign status.last = cnt == '0;

endmodule

@@ src/clipped_line_rasterizer.sv @@
// An accepted item is clipped into the endpoint registers, then set up in the stepping unit;
// each pixel then passes through the output register. A segment has at most MAX_DIM pixels,
// sent one per cycle while the output register is empty or being taken, else the unit stalls.
// The next item is taken once the last pixel of the current one has been loaded for output.
// Reset is synchronous and active high; it clears control state and sets both map sizes to 64.
module clipped_line_rasterizer
  import clr_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  clr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  clr_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/tb_clipped_line_rasterizer.sv @@
`timescale 1ns / 1ps

import clr_pkg::*;

class pixel_scoreboard;
  localparam int DIM_CAP = 64;

  out_item_t pending_pixels[$];
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  int errors;
  int segments;
  int pixels;

  function new();
    width_reg = MAP_DIM_RESET;
    height_reg = MAP_DIM_RESET;
    errors = 0;
    segments = 0;
    pixels = 0;
  endfunction

  function int eff_dim(logic [CFG_DATA_W-1:0] r);
    if (r == 0) return 1;
    if (r > DIM_CAP) return DIM_CAP;
    return int'(r);
  endfunction

  function int clip(int v, int dim);
    if (v < 0) return 0;
    if (v > dim - 1) return dim - 1;
    return v;
  endfunction

  function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MAP_WIDTH: width_reg = data;
      REG_MAP_HEIGHT: height_reg = data;
      default: ;
    endcase
  endfunction

  function void add_segment(in_item_t seg);
    int w, h, x1, y1, x2, y2, dx, dy, major, delta, mag, q, t, s;
    bit x_major;
    out_item_t pix;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    x1 = clip(int'(seg.x_start), w);
    y1 = clip(int'(seg.y_start), h);
    x2 = clip(int'(seg.x_end), w);
    y2 = clip(int'(seg.y_end), h);
    dx = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy = (y1 > y2) ? y1 - y2 : y2 - y1;
    x_major = dx > dy;
    if ((x_major && x1 > x2) || (!x_major && y1 > y2)) begin
      t = x1; x1 = x2; x2 = t;
      t = y1; y1 = y2; y2 = t;
    end
    major = x_major ? dx : dy;
    delta = x_major ? y2 - y1 : x2 - x1;
    mag = (delta < 0) ? -delta : delta;
    for (s = 0; s <= major; s++) begin
      q = (major == 0) ? 0 : (s * mag) / major;
      if (delta < 0) q = -q;
      if (x_major) begin
        pix.pixel_x = PIX_W'(x1 + s);
        pix.pixel_y = PIX_W'(y1 + q);
      end else begin
        pix.pixel_x = PIX_W'(x1 + q);
        pix.pixel_y = PIX_W'(y1 + s);
      end
      pix.last_pixel = (s == major);
      pending_pixels.push_back(pix);
    end
    segments++;
  endfunction

  function void check_pixel(out_item_t got);
    out_item_t want;
    pixels++;
    if (pending_pixels.size() == 0) begin
      $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
               got.pixel_x, got.pixel_y, got.last_pixel);
      errors++;
      return;
    end
    want = pending_pixels.pop_front();
    if (got.pixel_x !== want.pixel_x) begin
      $display("%0t: pixel_x expected %0d, actual %0d", $time, want.pixel_x, got.pixel_x);
      errors++;
    end
    if (got.pixel_y !== want.pixel_y) begin
      $display("%0t: pixel_y expected %0d, actual %0d", $time, want.pixel_y, got.pixel_y);
      errors++;
    end
    if (got.last_pixel !== want.last_pixel) begin
      $display("%0t: last_pixel expected %0b, actual %0b", $time,
               want.last_pixel, got.last_pixel);
      errors++;
    end
  endfunction
endclass

module tb_clipped_line_rasterizer;
  localparam int MAP_MAX = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 56;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {
    RX_STREAM,
    RX_COIN,
    RX_BURSTY
  } rx_mode_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  pixel_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left = 0;
  int settings_used = 1;
  rx_mode_t rx_mode = RX_STREAM;
  int rx_mode_left = 0;
  int rx_stall_left = 0;

  clipped_line_rasterizer #(.MAX_DIM(MAP_MAX)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped at cycle %0d with %0d pixels outstanding.", cycle_count,
               sb.pending_pixels.size());
      $display("tb_clipped_line_rasterizer: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.add_segment(in_data);
      if (out_valid === 1'b1 && out_ready) sb.check_pixel(out_data);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(20, 300);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_STREAM: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          if (rx_stall_left == 0) begin
            out_ready <= 1'b1;
            rx_stall_left = $urandom_range(1, 6);
          end else begin
            out_ready <= 1'b0;
            rx_stall_left--;
          end
        end
      endcase
    end
  end

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_segment(in_item_t seg);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= seg;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_coords(int xs, int ys, int xe, int ye);
    in_item_t seg;
    seg.x_start = COORD_W'(xs);
    seg.y_start = COORD_W'(ys);
    seg.x_end = COORD_W'(xe);
    seg.y_end = COORD_W'(ye);
    send_segment(seg);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (MAP_MAX + 8) @(posedge clk);
  endtask

  function automatic int rand_coord(int dim);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 15) return $urandom_range(0, dim - 1);
    if (pick < 17) return int'($urandom_range(0, dim + 7)) - 4;
    return int'($signed(16'($urandom)));
  endfunction

  initial begin
    int p, i, w, h;
    logic [CFG_DATA_W-1:0] wr, hr;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_coords(0, 0, 0, 0);
    send_coords(63, 63, 63, 63);
    send_coords(0, 0, 63, 0);
    send_coords(63, 5, 0, 5);
    send_coords(7, 0, 7, 63);
    send_coords(0, 0, 63, 63);
    send_coords(63, 0, 0, 63);
    send_coords(0, 10, 50, 3);
    send_coords(50, 3, 0, 10);
    send_coords(3, 60, 10, 0);
    send_coords(-32768, -32768, 32767, 32767);
    send_coords(32767, -32768, -32768, 32767);
    send_coords(-1, -1, -1, -1);
    send_coords(64, 64, 100, 200);
    send_coords(0, 0, 5, 3);
    send_coords(10, 20, 13, 26);
    send_coords(21845, -21846, 21845, -21846);
    send_coords(-21846, 21845, -21846, 21845);
    send_coords(1, 0, 0, 1);
    send_coords(40, 2, 2, 40);
    drain();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin wr = 7'd1; hr = 7'd1; end
        1: begin wr = 7'd0; hr = 7'd0; end
        2: begin wr = 7'd127; hr = 7'd127; end
        3: begin wr = 7'd64; hr = 7'd1; end
        4: begin wr = 7'd1; hr = 7'd64; end
        5: begin wr = 7'd65; hr = 7'd100; end
        6: begin wr = 7'd64; hr = 7'd64; end
        default: begin
          wr = CFG_DATA_W'($urandom_range(0, 127));
          hr = CFG_DATA_W'($urandom_range(0, 127));
        end
      endcase
      write_register(REG_MAP_WIDTH, wr);
      write_register(REG_MAP_HEIGHT, hr);
      if (p == 6) write_register(REG_SPARE, 7'd5);
      settings_used++;
      w = sb.eff_dim(wr);
      h = sb.eff_dim(hr);
      for (i = 0; i < PHASE_ITEMS; i++)
        send_coords(rand_coord(w), rand_coord(h), rand_coord(w), rand_coord(h));
      drain();
    end

    repeat (16) @(posedge clk);
    $display("Covered %0d segments and %0d pixels across %0d map settings.",
             sb.segments, sb.pixels, settings_used);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("tb_clipped_line_rasterizer: clean");
    end else begin
      $display("tb_clipped_line_rasterizer: errors");
    end
    $finish;
  end
endmodule
